// File: rtl/page_run_allocator_translator_assert.svh
// ----------------------------------------------------------------------------
// Page run allocator assertion macros
// Shared concurrent check forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PAGE_RUN_ALLOCATOR_TRANSLATOR_ASSERT_SVH
`define PAGE_RUN_ALLOCATOR_TRANSLATOR_ASSERT_SVH

// same-cycle implication
`define PRA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pra_pkg.sv
// ----------------------------------------------------------------------------
// Page run allocator package
// Shared types, codes and defaults of the page run allocator and translator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pra_pkg;

    localparam int ENTRIES_DEF       = 64;
    localparam int PAGE_BYTES_DEF    = 4096;
    localparam int MAX_RUN_PAGES_DEF = 255;

    localparam int ADDR_W   = 32;
    localparam int PAGES_W  = 8;
    localparam int OWNER_W  = 8;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;
    localparam int BUMP_W   = 14;
    localparam int CFG_IDX_W = 2;

    localparam logic [ACTION_W-1:0] ACT_HEAP_ALLOC  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_STACK_ALLOC = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_FREE        = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_V2R         = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_R2V         = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_TOP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_ADDR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REAL_BASE  = 2'd2;

    typedef enum logic [1:0] {
        KIND_FREE  = 2'd0,
        KIND_HEAP  = 2'd1,
        KIND_STACK = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [ADDR_W-1:0]  vbase;
        logic [PAGES_W-1:0] pages;
        logic [OWNER_W-1:0] owner;
    } entry_t;

    typedef struct packed {
        logic [ADDR_W-1:0] heap_top;
        logic [ADDR_W-1:0] stack_addr;
        logic [ADDR_W-1:0] real_base;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic              sub;
        logic [ADDR_W-1:0] x;
        logic [ADDR_W-1:0] y;
    } alu_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] sum;
        logic              eq;
    } alu_rsp_t;

endpackage

// File: rtl/pra_table.sv
// ----------------------------------------------------------------------------
// Page run table
// Single-port-write, registered-read memory of page run entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pra_table #(
    parameter int ENTRIES = pra_pkg::ENTRIES_DEF
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(ENTRIES)-1:0] wr_addr,
    input  pra_pkg::entry_t            wr_data,
    input  logic [$clog2(ENTRIES)-1:0] rd_addr,
    output pra_pkg::entry_t            rd_data
);
    import pra_pkg::*;

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/pra_alu.sv
// ----------------------------------------------------------------------------
// Page run shared arithmetic unit
// One 32-bit add/subtract and one 32-bit equality compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pra_alu (
    input  pra_pkg::alu_req_t req,
    output pra_pkg::alu_rsp_t rsp
);
    import pra_pkg::*;

    logic [ADDR_W-1:0] b_op;

    assign b_op    = req.sub ? ~req.b : req.b;
    assign rsp.sum = req.a + b_op + {{(ADDR_W-1){1'b0}}, req.sub};
    assign rsp.eq  = (req.x == req.y);

endmodule

// File: rtl/pra_ctrl.sv
// ----------------------------------------------------------------------------
// Page run sequencer
// Scans the run table one entry at a time and drives the shared unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "page_run_allocator_translator_assert.svh"

module pra_ctrl #(
    parameter int ENTRIES       = pra_pkg::ENTRIES_DEF,
    parameter int PAGE_BYTES    = pra_pkg::PAGE_BYTES_DEF,
    parameter int MAX_RUN_PAGES = pra_pkg::MAX_RUN_PAGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pra_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pra_pkg::ACTION_W-1:0]  action,
    input  logic [pra_pkg::PAGES_W-1:0]   page_count,
    input  logic [pra_pkg::ADDR_W-1:0]    address,
    input  logic [pra_pkg::OWNER_W-1:0]   requester_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pra_pkg::ADDR_W-1:0]    result_address,
    output logic [pra_pkg::STATUS_W-1:0]  status,
    output logic                          tbl_wr_en,
    output logic [$clog2(ENTRIES)-1:0]    tbl_wr_addr,
    output pra_pkg::entry_t               tbl_wr_data,
    output logic [$clog2(ENTRIES)-1:0]    tbl_rd_addr,
    input  pra_pkg::entry_t               tbl_rd_data,
    output pra_pkg::alu_req_t             alu_req,
    input  pra_pkg::alu_rsp_t             alu_rsp
);
    import pra_pkg::*;

    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int USED_W     = $clog2(ENTRIES + 1);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_BUMP,
        S_BASE,
        S_APPEND,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [ACTION_W-1:0]   action_reg;
    logic [PAGES_W-1:0]    pages_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [OWNER_W-1:0]    who_reg;
    logic [USED_W-1:0]     used_reg;
    logic [USED_W-1:0]     idx_reg;
    logic [BUMP_W-1:0]     bumped_reg;
    logic [BUMP_W:0]       bump_sum_reg;
    logic [ADDR_W-1:0]     base_reg;
    logic [ADDR_W-1:0]     run_real_reg;
    logic [ADDR_W-1:0]     res_addr_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic                  out_valid_reg;
    logic [ADDR_W-1:0]     out_addr_reg;
    logic [STATUS_W-1:0]   out_status_reg;

    logic                  own_ok;
    logic                  hit;
    logic                  table_full;
    logic                  table_empty;
    logic                  last_entry;
    logic                  alloc_bad;
    logic [USED_W-1:0]     idx_inc;

    assign table_full  = (used_reg == USED_W'(ENTRIES));
    assign table_empty = (used_reg == '0);
    assign idx_inc     = idx_reg + USED_W'(1);
    assign last_entry  = (idx_inc == used_reg);
    assign alloc_bad   = (page_count == '0) ||
                         (32'(page_count) > 32'(MAX_RUN_PAGES));

    always_comb
    begin
        own_ok = (tbl_rd_data.kind != KIND_STACK) || (tbl_rd_data.owner == who_reg);
        unique case (action_reg)
            ACT_HEAP_ALLOC: hit = (tbl_rd_data.kind == KIND_FREE) &&
                                  (tbl_rd_data.pages == pages_reg);
            ACT_FREE:       hit = alu_rsp.eq;
            ACT_V2R:        hit = alu_rsp.eq && own_ok;
            ACT_R2V:        hit = alu_rsp.eq && own_ok;
            default:        hit = 1'b0;
        endcase
    end

    always_comb
    begin
        alu_req.a   = run_real_reg;
        alu_req.b   = ADDR_W'(tbl_rd_data.pages) << PAGE_SHIFT;
        alu_req.sub = 1'b0;
        alu_req.x   = (action_reg == ACT_R2V) ? run_real_reg : tbl_rd_data.vbase;
        alu_req.y   = addr_reg;
        unique case (state_reg)
            S_BUMP:
            begin
                alu_req.a = ADDR_W'(bumped_reg);
                alu_req.b = ADDR_W'(pages_reg);
            end
            S_BASE:
            begin
                alu_req.sub = 1'b1;
                if (action_reg == ACT_HEAP_ALLOC)
                begin
                    alu_req.a = cfg.heap_top;
                    alu_req.b = ADDR_W'(bump_sum_reg) << PAGE_SHIFT;
                end
                else
                begin
                    alu_req.a = cfg.stack_addr;
                    alu_req.b = ADDR_W'(PAGE_BYTES);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        tbl_rd_addr       = idx_reg[IDX_W-1:0];
        tbl_wr_en         = 1'b0;
        tbl_wr_addr       = idx_reg[IDX_W-1:0];
        tbl_wr_data       = tbl_rd_data;
        tbl_wr_data.kind  = (action_reg == ACT_FREE) ? KIND_FREE : KIND_HEAP;
        if (state_reg == S_CHECK)
        begin
            tbl_wr_en = hit && ((action_reg == ACT_HEAP_ALLOC) || (action_reg == ACT_FREE));
        end
        else if (state_reg == S_APPEND)
        begin
            tbl_wr_en         = 1'b1;
            tbl_wr_addr       = used_reg[IDX_W-1:0];
            tbl_wr_data.vbase = base_reg;
            tbl_wr_data.pages = pages_reg;
            if (action_reg == ACT_HEAP_ALLOC)
            begin
                tbl_wr_data.kind  = KIND_HEAP;
                tbl_wr_data.owner = '0;
            end
            else
            begin
                tbl_wr_data.kind  = KIND_STACK;
                tbl_wr_data.owner = who_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            action_reg     <= '0;
            pages_reg      <= '0;
            addr_reg       <= '0;
            who_reg        <= '0;
            used_reg       <= '0;
            idx_reg        <= '0;
            bumped_reg     <= '0;
            bump_sum_reg   <= '0;
            base_reg       <= '0;
            run_real_reg   <= '0;
            res_addr_reg   <= '0;
            res_status_reg <= ST_OK;
            out_valid_reg  <= 1'b0;
            out_addr_reg   <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        action_reg     <= action;
                        pages_reg      <= page_count;
                        addr_reg       <= address;
                        who_reg        <= requester_id;
                        idx_reg        <= '0;
                        run_real_reg   <= cfg.real_base;
                        res_addr_reg   <= '0;
                        res_status_reg <= ST_INVALID;
                        state_reg      <= S_DONE;
                        unique case (action)
                            ACT_HEAP_ALLOC, ACT_STACK_ALLOC:
                            begin
                                if (alloc_bad)
                                begin
                                    state_reg <= S_DONE;
                                end
                                else if ((action == ACT_HEAP_ALLOC) && !table_empty)
                                begin
                                    state_reg <= S_READ;
                                end
                                else if (table_full)
                                begin
                                    res_status_reg <= ST_FULL;
                                end
                                else if (action == ACT_HEAP_ALLOC)
                                begin
                                    state_reg <= S_BUMP;
                                end
                                else
                                begin
                                    state_reg <= S_BASE;
                                end
                            end
                            ACT_FREE:
                            begin
                                if (page_count == '0)
                                begin
                                    state_reg <= S_DONE;
                                end
                                else if (table_empty)
                                begin
                                    res_status_reg <= ST_MISS;
                                end
                                else
                                begin
                                    state_reg <= S_READ;
                                end
                            end
                            ACT_V2R, ACT_R2V:
                            begin
                                if (table_empty)
                                begin
                                    res_status_reg <= ST_MISS;
                                end
                                else
                                begin
                                    state_reg <= S_READ;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (hit)
                    begin
                        res_status_reg <= ST_OK;
                        state_reg      <= S_DONE;
                        unique case (action_reg)
                            ACT_V2R:  res_addr_reg <= run_real_reg;
                            ACT_FREE: res_addr_reg <= '0;
                            default:  res_addr_reg <= tbl_rd_data.vbase;
                        endcase
                    end
                    else
                    begin
                        run_real_reg <= alu_rsp.sum;
                        idx_reg      <= idx_inc;
                        if (!last_entry)
                        begin
                            state_reg <= S_READ;
                        end
                        else if (action_reg != ACT_HEAP_ALLOC)
                        begin
                            res_status_reg <= ST_MISS;
                            state_reg      <= S_DONE;
                        end
                        else if (table_full)
                        begin
                            res_status_reg <= ST_FULL;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_BUMP;
                        end
                    end
                end
                S_BUMP:
                begin
                    bump_sum_reg <= alu_rsp.sum[BUMP_W:0];
                    state_reg    <= S_BASE;
                end
                S_BASE:
                begin
                    base_reg <= alu_rsp.sum;
                    if (action_reg == ACT_HEAP_ALLOC)
                    begin
                        bumped_reg   <= bump_sum_reg[BUMP_W-1:0];
                        res_addr_reg <= alu_rsp.sum;
                    end
                    else
                    begin
                        res_addr_reg <= cfg.stack_addr;
                    end
                    state_reg <= S_APPEND;
                end
                S_APPEND:
                begin
                    used_reg       <= used_reg + USED_W'(1);
                    res_status_reg <= ST_OK;
                    state_reg      <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_addr_reg   <= res_addr_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign result_address = out_addr_reg;
    assign status         = out_status_reg;

    `PRA_ASSERT_SAME(a_used_bound, 1'b1, used_reg <= USED_W'(ENTRIES), "entry count over capacity")
    `PRA_ASSERT_NEXT(a_append_grows, state_reg == S_APPEND, used_reg == $past(used_reg) + USED_W'(1), "append did not grow table")
    `PRA_ASSERT_SAME(a_err_zero, out_valid_reg && (out_status_reg != ST_OK), out_addr_reg == '0, "nonzero address on error word")
    `PRA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready held after accept")

endmodule

// File: rtl/page_run_allocator_translator.sv
// ----------------------------------------------------------------------------
// Page run allocator and translator
// Allocates heap and stack page runs, frees runs and translates virtual/real addresses.
// ----------------------------------------------------------------------------
// channel | direction | handshake                | payload
// in      | input     | in_valid / in_ready      | action, page_count, address, requester_id
// out     | output    | out_valid / out_ready    | result_address, status
// cfg     | input     | cfg_write_enable         | cfg_index, cfg_data
//
// A word scans the table one entry at a time (registered table read, then
// compare and running real address add in the shared unit), followed by
// setup, append and result load.
// Reset clears the entry count, the bump counter and the config registers;
// the table itself needs no clearing pass.
// A result waits in the output register while the next word is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_run_allocator_translator #(
    parameter int ENTRIES       = pra_pkg::ENTRIES_DEF,
    parameter int PAGE_BYTES    = pra_pkg::PAGE_BYTES_DEF,
    parameter int MAX_RUN_PAGES = pra_pkg::MAX_RUN_PAGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_enable,
    input  logic [pra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pra_pkg::ADDR_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pra_pkg::ACTION_W-1:0]  action,
    input  logic [pra_pkg::PAGES_W-1:0]   page_count,
    input  logic [pra_pkg::ADDR_W-1:0]    address,
    input  logic [pra_pkg::OWNER_W-1:0]   requester_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pra_pkg::ADDR_W-1:0]    result_address,
    output logic [pra_pkg::STATUS_W-1:0]  status
);
    import pra_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    cfg_t              cfg_reg;
    logic              tbl_wr_en;
    logic [IDX_W-1:0]  tbl_wr_addr;
    entry_t            tbl_wr_data;
    logic [IDX_W-1:0]  tbl_rd_addr;
    entry_t            tbl_rd_data;
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                CFG_HEAP_TOP:   cfg_reg.heap_top   <= cfg_data;
                CFG_STACK_ADDR: cfg_reg.stack_addr <= cfg_data;
                CFG_REAL_BASE:  cfg_reg.real_base  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    pra_ctrl #(
        .ENTRIES       (ENTRIES),
        .PAGE_BYTES    (PAGE_BYTES),
        .MAX_RUN_PAGES (MAX_RUN_PAGES)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .page_count     (page_count),
        .address        (address),
        .requester_id   (requester_id),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_address (result_address),
        .status         (status),
        .tbl_wr_en      (tbl_wr_en),
        .tbl_wr_addr    (tbl_wr_addr),
        .tbl_wr_data    (tbl_wr_data),
        .tbl_rd_addr    (tbl_rd_addr),
        .tbl_rd_data    (tbl_rd_data),
        .alu_req        (alu_req),
        .alu_rsp        (alu_rsp)
    );

    pra_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    pra_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

endmodule
